@@ hw/rtl/faraday_m4_stencil_1d_assert.svh @@
// Assertion helpers for the stencil block; clocked on clk, disabled in rst.
`ifndef FARADAY_M4_STENCIL_1D_ASSERT_SVH
`define FARADAY_M4_STENCIL_1D_ASSERT_SVH

// Same-cycle implication.
`define FM4S_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fm4s assertion failed");

// Next-cycle implication.
`define FM4S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fm4s assertion failed");

`endif

@@ hw/rtl/fm4s_pkg.sv @@
`default_nettype none
package fm4s_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 30;
  localparam int CNT_W     = 13;
  localparam int IDX_W     = 12;
  localparam int MIN_CELLS = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FAR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT   = 2'd3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_EDGE,
    CLS_FULL
  } cell_class_t;

  typedef struct packed {
    logic [IDX_W-1:0]          cell_index;
    logic signed [FIELD_W-1:0] b_y_new;
    logic signed [FIELD_W-1:0] b_z_new;
    logic                      sweep_end;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/fm4s_in_if.sv @@
`default_nettype none
interface fm4s_in_if import fm4s_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] e_z;
  logic signed [FIELD_W-1:0] e_y;
  logic signed [FIELD_W-1:0] b_y_old;
  logic signed [FIELD_W-1:0] b_z_old;

  modport source (output valid, e_z, e_y, b_y_old, b_z_old, input ready);
  modport sink (input valid, e_z, e_y, b_y_old, b_z_old, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fm4s_out_if.sv @@
`default_nettype none
interface fm4s_out_if import fm4s_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          cell_index;
  logic signed [FIELD_W-1:0] b_y_new;
  logic signed [FIELD_W-1:0] b_z_new;
  logic                      sweep_end;

  modport source (output valid, cell_index, b_y_new, b_z_new, sweep_end, input ready);
  modport sink (input valid, cell_index, b_y_new, b_z_new, sweep_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/faraday_m4_stencil_1d.sv @@
`default_nettype none
// Streaming 1D Faraday update with the four-point M4 stencil. Cells of a sweep enter in
// order on "cells", one per cycle while ready is high; the result for a cell leaves on
// "results" after the next cell has arrived, and the final cell of a sweep (index
// num_cells-1, num_cells clamped to 4..4096) yields its own pass-through result as
// well, flagged sweep_end. Sustained rate is one cell per clock with results drained
// every cycle. A cell's result passes the difference registers loaded on accept, the
// multiply/round stage and sum/saturate into the result queue. Input ready is held by
// credit on an 8-entry result queue, so a stalled output stops input after a few cells.
// Coefficients and num_cells are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
`include "faraday_m4_stencil_1d_assert.svh"
module faraday_m4_stencil_1d
  import fm4s_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  fm4s_in_if.sink                    cells,
  fm4s_out_if.source                 results
);

  localparam int DIFF_W     = FIELD_W + 1;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int TERM_W     = PROD_W - COEF_FRAC;
  localparam int SUM_W      = TERM_W + 2;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = FIFO_AW + 2;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [SUM_W-1:0]  SAT_MAX =
    SUM_W'({1'b0, {(FIELD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  SAT_MIN = -SAT_MAX - SUM_W'(1);

  function automatic logic signed [TERM_W-1:0] mul_round(
    input logic signed [DIFF_W-1:0] d,
    input logic signed [COEF_W-1:0] k
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    prod    = PROD_W'(d) * PROD_W'(k);
    shifted = (prod + ROUND_HALF) >>> COEF_FRAC;
    return $signed(shifted[TERM_W-1:0]);
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[FIELD_W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[FIELD_W-1:0];
    end
    return v[FIELD_W-1:0];
  endfunction

  // configuration
  logic [CNT_W-1:0]         num_cells;
  logic signed [COEF_W-1:0] coef_main;
  logic signed [COEF_W-1:0] coef_far;
  logic signed [COEF_W-1:0] courant;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells <= CNT_W'(MAX_CELLS);
      coef_main <= COEF_W'(1) << COEF_FRAC;
      coef_far  <= '0;
      courant   <= COEF_W'(1) << COEF_FRAC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_CELLS: num_cells <= cfg_data[CNT_W-1:0];
        REG_COEF_MAIN: coef_main <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_FAR:  coef_far  <= $signed(cfg_data[COEF_W-1:0]);
        REG_COURANT:   courant   <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // stream state
  logic signed [FIELD_W-1:0] ez_window [3];
  logic signed [FIELD_W-1:0] ey_window [3];
  logic signed [FIELD_W-1:0] by_held;
  logic signed [FIELD_W-1:0] bz_held;
  logic [CNT_W-1:0]          cell_count;
  logic [CNT_W-1:0]          cell_count_next;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] n_m2;
  logic [CNT_W-1:0] prev_cell;
  logic             last;
  logic             accept;
  cell_class_t      cls;

  always_comb begin
    if (num_cells < CNT_W'(MIN_CELLS)) begin
      n_eff = CNT_W'(MIN_CELLS);
    end else if (num_cells > CNT_W'(MAX_CELLS)) begin
      n_eff = CNT_W'(MAX_CELLS);
    end else begin
      n_eff = num_cells;
    end
    n_m1      = n_eff - CNT_W'(1);
    n_m2      = n_eff - CNT_W'(2);
    prev_cell = cell_count - CNT_W'(1);
    last      = cell_count >= n_m1;
    if (prev_cell == '0 || prev_cell >= n_m1) begin
      cls = CLS_PASS;
    end else if (prev_cell == CNT_W'(1) || prev_cell == n_m2) begin
      cls = CLS_EDGE;
    end else begin
      cls = CLS_FULL;
    end
    cell_count_next = last ? '0 : cell_count + CNT_W'(1);
  end

  // stage 1: differences
  logic                     s1_va;
  logic                     s1_vb;
  cell_class_t              s1_cls;
  logic [IDX_W-1:0]         s1_idx_a;
  logic [IDX_W-1:0]         s1_idx_b;
  logic signed [DIFF_W-1:0] s1_dz_near;
  logic signed [DIFF_W-1:0] s1_dz_far;
  logic signed [DIFF_W-1:0] s1_dy_near;
  logic signed [DIFF_W-1:0] s1_dy_far;
  logic signed [FIELD_W-1:0] s1_by_held;
  logic signed [FIELD_W-1:0] s1_bz_held;
  logic signed [FIELD_W-1:0] s1_by_in;
  logic signed [FIELD_W-1:0] s1_bz_in;

  // stage 2: rounded products
  logic                     s2_va;
  logic                     s2_vb;
  logic [IDX_W-1:0]         s2_idx_a;
  logic [IDX_W-1:0]         s2_idx_b;
  logic signed [TERM_W-1:0] s2_tz_near;
  logic signed [TERM_W-1:0] s2_tz_far;
  logic signed [TERM_W-1:0] s2_ty_near;
  logic signed [TERM_W-1:0] s2_ty_far;
  logic signed [FIELD_W-1:0] s2_by_held;
  logic signed [FIELD_W-1:0] s2_bz_held;
  logic signed [FIELD_W-1:0] s2_by_in;
  logic signed [FIELD_W-1:0] s2_bz_in;

  // result queue
  result_t            fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fifo_count;
  logic [CRED_W-1:0]  inflight;
  logic               pop;

  assign inflight = CRED_W'(s1_va) + CRED_W'(s1_vb) + CRED_W'(s2_va) + CRED_W'(s2_vb);
  assign cells.ready = (CRED_W'(fifo_count) + inflight + CRED_W'(2))
                       <= CRED_W'(FIFO_DEPTH);
  assign accept = cells.valid && cells.ready;
  assign pop    = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ez_window[i] <= '0;
        ey_window[i] <= '0;
      end
      by_held    <= '0;
      bz_held    <= '0;
      cell_count <= '0;
      s1_va      <= 1'b0;
      s1_vb      <= 1'b0;
    end else begin
      s1_va <= accept && (cell_count != '0);
      s1_vb <= accept && last;
      if (accept) begin
        ez_window[2] <= ez_window[1];
        ez_window[1] <= ez_window[0];
        ez_window[0] <= cells.e_z;
        ey_window[2] <= ey_window[1];
        ey_window[1] <= ey_window[0];
        ey_window[0] <= cells.e_y;
        by_held      <= cells.b_y_old;
        bz_held      <= cells.b_z_old;
        cell_count   <= cell_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls     <= cls;
      s1_idx_a   <= prev_cell[IDX_W-1:0];
      s1_idx_b   <= cell_count[IDX_W-1:0];
      s1_dz_near <= DIFF_W'(ez_window[0]) - DIFF_W'(ez_window[1]);
      s1_dz_far  <= DIFF_W'(cells.e_z) - DIFF_W'(ez_window[2]);
      s1_dy_near <= DIFF_W'(ey_window[0]) - DIFF_W'(ey_window[1]);
      s1_dy_far  <= DIFF_W'(cells.e_y) - DIFF_W'(ey_window[2]);
      s1_by_held <= by_held;
      s1_bz_held <= bz_held;
      s1_by_in   <= cells.b_y_old;
      s1_bz_in   <= cells.b_z_old;
    end
  end

  // pass-through cells get zero weights, so the sum stage leaves B as it was
  logic signed [COEF_W-1:0] k_near;
  logic signed [COEF_W-1:0] k_far;

  always_comb begin
    case (s1_cls)
      CLS_EDGE: begin
        k_near = courant;
        k_far  = '0;
      end
      CLS_FULL: begin
        k_near = coef_main;
        k_far  = coef_far;
      end
      default: begin
        k_near = '0;
        k_far  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_va <= 1'b0;
      s2_vb <= 1'b0;
    end else begin
      s2_va <= s1_va;
      s2_vb <= s1_vb;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx_a   <= s1_idx_a;
    s2_idx_b   <= s1_idx_b;
    s2_tz_near <= mul_round(s1_dz_near, k_near);
    s2_tz_far  <= mul_round(s1_dz_far, k_far);
    s2_ty_near <= mul_round(s1_dy_near, k_near);
    s2_ty_far  <= mul_round(s1_dy_far, k_far);
    s2_by_held <= s1_by_held;
    s2_bz_held <= s1_bz_held;
    s2_by_in   <= s1_by_in;
    s2_bz_in   <= s1_bz_in;
  end

  // stage 3: sum, saturate, queue
  logic signed [SUM_W-1:0] by_sum;
  logic signed [SUM_W-1:0] bz_sum;
  result_t                 res_a;
  result_t                 res_b;
  logic [FIFO_AW:0]        fifo_count_next;

  always_comb begin
    by_sum = SUM_W'(s2_by_held) + SUM_W'(s2_tz_near) + SUM_W'(s2_tz_far);
    bz_sum = SUM_W'(s2_bz_held) - SUM_W'(s2_ty_near) - SUM_W'(s2_ty_far);
    res_a.cell_index = s2_idx_a;
    res_a.b_y_new    = sat_field(by_sum);
    res_a.b_z_new    = sat_field(bz_sum);
    res_a.sweep_end  = 1'b0;
    res_b.cell_index = s2_idx_b;
    res_b.b_y_new    = s2_by_in;
    res_b.b_z_new    = s2_bz_in;
    res_b.sweep_end  = 1'b1;
    fifo_count_next  = fifo_count + (FIFO_AW+1)'(s2_va) + (FIFO_AW+1)'(s2_vb)
                       - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (s2_va) begin
      fifo[wr_ptr] <= res_a;
    end
    if (s2_vb) begin
      fifo[wr_ptr + FIFO_AW'(s2_va)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(s2_va) + FIFO_AW'(s2_vb);
      rd_ptr     <= rd_ptr + FIFO_AW'(pop);
      fifo_count <= fifo_count_next;
    end
  end

  assign results.valid      = fifo_count != '0;
  assign results.cell_index = fifo[rd_ptr].cell_index;
  assign results.b_y_new    = fifo[rd_ptr].b_y_new;
  assign results.b_z_new    = fifo[rd_ptr].b_z_new;
  assign results.sweep_end  = fifo[rd_ptr].sweep_end;

  `FM4S_ASSERT_NOW(a_queue_bound, 1'b1, fifo_count <= (FIFO_AW+1)'(FIFO_DEPTH))
  `FM4S_ASSERT_NOW(a_push_fits, s2_va || s2_vb,
    (CRED_W'(s2_va) + CRED_W'(s2_vb) + CRED_W'(fifo_count)) <= CRED_W'(FIFO_DEPTH))
  `FM4S_ASSERT_NEXT(a_sweep_wrap, accept && last, cell_count == '0 && s1_vb)

endmodule
`default_nettype wire

@@ dv/tb_faraday_m4_stencil_1d.sv @@
`timescale 1ns / 1ps
module tb_faraday_m4_stencil_1d;
  import fm4s_pkg::*;

  localparam int LIMIT_CYCLES  = 800_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 1800;

  typedef struct packed {
    logic signed [FIELD_W-1:0] e_z;
    logic signed [FIELD_W-1:0] e_y;
    logic signed [FIELD_W-1:0] b_y_old;
    logic signed [FIELD_W-1:0] b_z_old;
  } grid_cell_t;

  typedef enum logic { ROW_WRITE, ROW_CELL } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    grid_cell_t            fields;
    int                    n_typed;  // -1: results come from the predictor
    result_t               want0;
    result_t               want1;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fm4s_in_if  in_ch();
  fm4s_out_if out_ch();

  faraday_m4_stencil_1d dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (in_ch),
    .results   (out_ch)
  );

  // predictor copy of registers and stencil state
  logic [CNT_W-1:0]          ncells_reg;
  logic signed [COEF_W-1:0]  k_main;
  logic signed [COEF_W-1:0]  k_far;
  logic signed [COEF_W-1:0]  k_edge;
  logic signed [FIELD_W-1:0] ez_hist [3];
  logic signed [FIELD_W-1:0] ey_hist [3];
  logic signed [FIELD_W-1:0] by_prev;
  logic signed [FIELD_W-1:0] bz_prev;
  logic [CNT_W-1:0]          next_idx;

  result_t     b_updates_due [$];
  stim_row_t   dir_rows [$];
  int          errors = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_faraday_m4_stencil_1d NOT OK");
      $finish;
    end
  end

  // coef * (a - b) in Q1.30, rounded half up back to Q7.24
  function automatic logic signed [71:0] round_term(input logic signed [COEF_W-1:0] k,
                                                    input logic signed [FIELD_W-1:0] a,
                                                    input logic signed [FIELD_W-1:0] b);
    logic signed [71:0] d;
    logic signed [71:0] prod;
    d = a;
    d = d - b;
    prod = d * k;
    return (prod + 72'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [71:0] v);
    if (v > 72'sh7FFFFFFF) return 32'sh7FFFFFFF;
    else if (v < -72'sh80000000) return 32'sh80000000;
    else return v[FIELD_W-1:0];
  endfunction

  function automatic result_t upd(input int idx, input logic [FIELD_W-1:0] by,
                                  input logic [FIELD_W-1:0] bz, input bit last);
    result_t r;
    r.cell_index = idx[IDX_W-1:0];
    r.b_y_new    = by;
    r.b_z_new    = bz;
    r.sweep_end  = last;
    return r;
  endfunction

  // advances the stencil by one cell, returns how many B updates it releases
  function automatic int faraday_step(input grid_cell_t c, output result_t r0,
                                      output result_t r1);
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   p;
    cell_class_t        cls;
    logic signed [71:0] sy;
    logic signed [71:0] sz;
    result_t            tail;
    int                 cnt;
    n = ncells_reg;
    if (n < CNT_W'(MIN_CELLS)) n = CNT_W'(MIN_CELLS);
    if (n > CNT_W'(MAX_CELLS)) n = CNT_W'(MAX_CELLS);
    cnt = 0;
    r0 = '0;
    r1 = '0;
    if (next_idx != '0) begin
      p = next_idx - CNT_W'(1);
      if (p == '0 || p >= n - CNT_W'(1)) cls = CLS_PASS;
      else if (p == CNT_W'(1) || p == n - CNT_W'(2)) cls = CLS_EDGE;
      else cls = CLS_FULL;
      sy = by_prev;
      sz = bz_prev;
      case (cls)
        CLS_EDGE: begin
          sy = sy + round_term(k_edge, ez_hist[0], ez_hist[1]);
          sz = sz - round_term(k_edge, ey_hist[0], ey_hist[1]);
        end
        CLS_FULL: begin
          sy = sy + round_term(k_main, ez_hist[0], ez_hist[1])
                  + round_term(k_far, c.e_z, ez_hist[2]);
          sz = sz - round_term(k_main, ey_hist[0], ey_hist[1])
                  - round_term(k_far, c.e_y, ey_hist[2]);
        end
        default: ;
      endcase
      r0 = upd(int'(p), sat_field(sy), sat_field(sz), 1'b0);
      cnt = 1;
    end
    if (next_idx >= n - CNT_W'(1)) begin
      tail = upd(int'(next_idx), c.b_y_old, c.b_z_old, 1'b1);
      if (cnt == 0) r0 = tail;
      else r1 = tail;
      cnt++;
      next_idx = '0;
    end else begin
      next_idx = next_idx + CNT_W'(1);
    end
    ez_hist[2] = ez_hist[1];
    ez_hist[1] = ez_hist[0];
    ez_hist[0] = c.e_z;
    ey_hist[2] = ey_hist[1];
    ey_hist[1] = ey_hist[0];
    ey_hist[0] = c.e_y;
    by_prev = c.b_y_old;
    bz_prev = c.b_z_old;
    return cnt;
  endfunction

  function automatic stim_row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    r.fields  = '0;
    r.n_typed = 0;
    r.want0   = '0;
    r.want1   = '0;
    return r;
  endfunction

  function automatic stim_row_t cell_row(input logic [FIELD_W-1:0] ez,
                                         input logic [FIELD_W-1:0] ey,
                                         input logic [FIELD_W-1:0] by,
                                         input logic [FIELD_W-1:0] bz,
                                         input int n_typed, input result_t w0,
                                         input result_t w1);
    stim_row_t r;
    r.kind    = ROW_CELL;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.fields  = '{e_z: ez, e_y: ey, b_y_old: by, b_z_old: bz};
    r.n_typed = n_typed;
    r.want0   = w0;
    r.want1   = w1;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rnd_field();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h03FFFFFF) - 32'h02000000;  // about +-2.0
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rnd_coef();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h00000000;
      3: return 32'h40000000;
      4, 5, 6: return $urandom;
      7: return $urandom_range(0, 15) - 8;  // tiny weights stress rounding
      default: return $urandom_range(0, 32'h7FFFFFFF) - 32'h40000000;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_NUM_CELLS: ncells_reg = val[CNT_W-1:0];
      REG_COEF_MAIN: k_main = val;
      REG_COEF_FAR:  k_far = val;
      REG_COURANT:   k_edge = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drain everything in flight, including a first cell that releases nothing yet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (b_updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_cell(input stim_row_t row);
    int      gap;
    int      nres;
    result_t r0;
    result_t r1;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.e_z     <= row.fields.e_z;
    in_ch.e_y     <= row.fields.e_y;
    in_ch.b_y_old <= row.fields.b_y_old;
    in_ch.b_z_old <= row.fields.b_z_old;
    do @(posedge clk); while (!in_ch.ready);
    nres = faraday_step(row.fields, r0, r1);
    if (row.n_typed >= 0) begin
      if (row.n_typed > 0) b_updates_due.push_back(row.want0);
      if (row.n_typed > 1) b_updates_due.push_back(row.want1);
    end else begin
      if (nres > 0) b_updates_due.push_back(r0);
      if (nres > 1) b_updates_due.push_back(r1);
    end
  endtask

  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = $urandom_range(4, 12);
      5, 6: n = $urandom_range(13, 80);
      7: n = $urandom_range(0, 3);
      8: n = $urandom_range(MAX_CELLS + 1, 8191);
      default: n = MIN_CELLS;
    endcase
    if ($urandom_range(0, 1)) write_reg(REG_NUM_CELLS, n);
    if ($urandom_range(0, 1)) write_reg(REG_COEF_MAIN, rnd_coef());
    if ($urandom_range(0, 1)) write_reg(REG_COEF_FAR, rnd_coef());
    if ($urandom_range(0, 1)) write_reg(REG_COURANT, rnd_coef());
  endtask

  function automatic void check_update(input result_t got);
    result_t want;
    if (b_updates_due.size() == 0) begin
      $display("%0t: unexpected B update: cell %0d by %h bz %h end %0b", $time,
               got.cell_index, got.b_y_new, got.b_z_new, got.sweep_end);
      errors++;
      return;
    end
    want = b_updates_due.pop_front();
    if (got.cell_index !== want.cell_index) begin
      $display("%0t: cell_index expected %0d got %0d", $time, want.cell_index, got.cell_index);
      errors++;
    end
    if (got.b_y_new !== want.b_y_new) begin
      $display("%0t: b_y_new of cell %0d expected %h got %h", $time, want.cell_index,
               want.b_y_new, got.b_y_new);
      errors++;
    end
    if (got.b_z_new !== want.b_z_new) begin
      $display("%0t: b_z_new of cell %0d expected %h got %h", $time, want.cell_index,
               want.b_z_new, got.b_z_new);
      errors++;
    end
    if (got.sweep_end !== want.sweep_end) begin
      $display("%0t: sweep_end of cell %0d expected %0b got %0b", $time, want.cell_index,
               want.sweep_end, got.sweep_end);
      errors++;
    end
  endfunction

  // result sink with random back-pressure
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_update('{cell_index: out_ch.cell_index, b_y_new: out_ch.b_y_new,
                     b_z_new: out_ch.b_z_new, sweep_end: out_ch.sweep_end});
    end
  end

  initial begin
    int sent;
    int len;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.e_z     <= '0;
    in_ch.e_y     <= '0;
    in_ch.b_y_old <= '0;
    in_ch.b_z_old <= '0;
    ncells_reg = 13'd4096;
    k_main     = 32'sh40000000;
    k_far      = '0;
    k_edge     = 32'sh40000000;
    for (int i = 0; i < 3; i++) begin
      ez_hist[i] = '0;
      ey_hist[i] = '0;
    end
    by_prev  = '0;
    bz_prev  = '0;
    next_idx = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // shortest sweep at reset weights: saturation both ways, both boundary cells
    dir_rows.push_back(wr_row(REG_NUM_CELLS, 4));
    dir_rows.push_back(cell_row(32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 0, '0, '0));
    dir_rows.push_back(cell_row(32'h01000000, 32'h01000000, 32'h7FFFFFFF, 32'h80000000, 1,
                                upd(0, 32'h7FFFFFFF, 32'h80000000, 1'b0), '0));
    dir_rows.push_back(cell_row(32'h03000000, 32'h0, 32'h0, 32'h0, 1,
                                upd(1, 32'h7FFFFFFF, 32'h80000000, 1'b0), '0));
    dir_rows.push_back(cell_row(32'h80000000, 32'h7FFFFFFF, 32'h12345678, 32'hFEDCBA98, 2,
                                upd(2, 32'h02000000, 32'h01000000, 1'b0),
                                upd(3, 32'h12345678, 32'hFEDCBA98, 1'b1)));
    // one-LSB courant: exact half rounds up for both signs
    dir_rows.push_back(wr_row(REG_COURANT, 1));
    dir_rows.push_back(cell_row(32'h0, 32'h0, 32'd5, 32'd5, 0, '0, '0));
    dir_rows.push_back(cell_row(32'h20000000, 32'hE0000000, 32'd10, 32'd10, 1,
                                upd(0, 32'd5, 32'd5, 1'b0), '0));
    dir_rows.push_back(cell_row(32'h0, 32'h0, 32'h0, 32'h0, 1,
                                upd(1, 32'd11, 32'd10, 1'b0), '0));
    dir_rows.push_back(cell_row(32'h7FFFFFFF, 32'h80000000, 32'd7, 32'd8, 2,
                                upd(2, 32'h0, 32'hFFFFFFFF, 1'b0),
                                upd(3, 32'd7, 32'd8, 1'b1)));
    // full stencil with extreme weights and alternating extreme fields
    dir_rows.push_back(wr_row(REG_NUM_CELLS, 6));
    dir_rows.push_back(wr_row(REG_COEF_MAIN, 32'h7FFFFFFF));
    dir_rows.push_back(wr_row(REG_COEF_FAR, 32'h80000000));
    dir_rows.push_back(wr_row(REG_COURANT, 32'hC0000000));
    dir_rows.push_back(cell_row(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'h80000000, 32'h7FFFFFFF, 32'h01000000, 32'hFF000000, -1,
                                '0, '0));
    dir_rows.push_back(cell_row(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, -1,
                                '0, '0));
    dir_rows.push_back(cell_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, -1,
                                '0, '0));
    dir_rows.push_back(cell_row(32'h00800000, 32'hFF800000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'hFFFFFFFF, 32'h00000001, 32'h00000001, 32'hFFFFFFFF, -1,
                                '0, '0));
    // num_cells below the floor runs as four cells
    dir_rows.push_back(wr_row(REG_NUM_CELLS, 0));
    dir_rows.push_back(cell_row(32'h00100000, 32'h00200000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'hFFF00000, 32'h00300000, 32'h1, 32'h2, -1, '0, '0));
    dir_rows.push_back(cell_row(32'h00400000, 32'hFFC00000, 32'h3, 32'h4, -1, '0, '0));
    dir_rows.push_back(cell_row(32'h0, 32'h0, 32'h5, 32'h6, -1, '0, '0));
    // oversize count clamps to the maximum; lowering it mid-sweep ends the sweep early
    dir_rows.push_back(wr_row(REG_NUM_CELLS, 32'h1FFF));
    dir_rows.push_back(cell_row(32'h01000000, 32'h02000000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'h02000000, 32'h01000000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'h04000000, 32'hFC000000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'hF8000000, 32'h08000000, 32'h0, 32'h0, -1, '0, '0));
    dir_rows.push_back(cell_row(32'h10000000, 32'hF0000000, 32'h0000AAAA, 32'h00005555, -1,
                                '0, '0));
    dir_rows.push_back(wr_row(REG_NUM_CELLS, 4));
    dir_rows.push_back(cell_row(32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 2,
                                upd(4, 32'h0000AAAA, 32'h00005555, 1'b0),
                                upd(5, 32'h7FFFFFFF, 32'h80000000, 1'b1)));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        push_cell(dir_rows[i]);
      end
    end

    // random phases; sweeps run on across config changes
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      shuffle_config();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      len = $urandom_range(5, 60);
      repeat (len) begin
        push_cell(cell_row(rnd_field(), rnd_field(), rnd_field(), rnd_field(), -1, '0, '0));
      end
      sent += len;
    end

    in_ch.valid <= 1'b0;
    while (b_updates_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_faraday_m4_stencil_1d OK");
    else $display("tb_faraday_m4_stencil_1d NOT OK");
    $finish;
  end

endmodule
